// File: hw/rtl/cst_pkg.sv
// Shared types and constants for the cosine similarity threshold block.
`default_nettype none

package cst_pkg;

    localparam int SUM_W      = 43;          // running sums, Q13.30
    localparam int PROD_W     = 2 * SUM_W;   // norm_a * norm_b
    localparam int HALF_W     = 22;          // operand split for the product
    localparam int ROOT_W     = SUM_W;       // sqrt of PROD_W bits
    localparam int REM_W      = ROOT_W + 2;  // sqrt partial remainder
    localparam int Q_W        = 15;          // quotient magnitude bits
    localparam int CNT_W      = 6;
    localparam int MUL_STEPS  = 4;
    localparam int SQRT_STEPS = PROD_W / 2;
    localparam int DIV_STEPS  = Q_W;

    localparam logic signed [15:0] THRESHOLD_RESET = 16'sd11469;
    localparam logic signed [15:0] SIM_MAX         = 16'sd32767;
    localparam logic signed [15:0] SIM_MIN         = -16'sd32768;

    typedef struct packed {
        logic signed [15:0] elem_a;
        logic signed [15:0] elem_b;
        logic               last;
    } pair_t;

    typedef struct packed {
        logic signed [15:0] similarity;
        logic               above_threshold;
        logic               zero_norm;
    } result_t;

    typedef enum logic [2:0] {
        S_ACCUM,
        S_MUL,
        S_SQRT,
        S_PREP,
        S_DIV,
        S_DONE
    } state_t;

    typedef struct packed {
        logic       accum;
        logic       mul_step;
        logic [1:0] mul_sel;
        logic       sqrt_step;
        logic       div_prep;
        logic       div_step;
        logic       load;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/cst_ctrl.sv
// Controller: sequences accumulate, product, square root and divide.
`default_nettype none

module cst_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pair_fire,
    input  logic          pair_last,
    input  cst_pkg::sts_t sts,
    output cst_pkg::cmd_t cmd,
    output logic          busy
);
    import cst_pkg::*;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_ACCUM;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_ACCUM:
            begin
                cmd.accum = pair_fire;
                if (pair_fire && pair_last)
                begin
                    state_next = S_MUL;
                    cnt_next   = '0;
                end
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                cmd.mul_sel  = cnt_reg[1:0];
                if (cnt_reg == CNT_W'(MUL_STEPS - 1))
                begin
                    state_next = S_SQRT;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                begin
                    state_next = S_PREP;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_PREP:
            begin
                cmd.div_prep = 1'b1;
                state_next   = S_DIV;
                cnt_next     = '0;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_DONE;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_ACCUM;
                end
            end
            default:
            begin
                state_next = S_ACCUM;
                cnt_next   = '0;
            end
        endcase
    end

    assign busy = (state_reg != S_ACCUM);

endmodule

`default_nettype wire

// File: hw/rtl/cst_dpath.sv
// Datapath: sums, split product, digit square root, restoring divide, result register.
`default_nettype none

module cst_dpath (
    input  logic             clk,
    input  logic             rst_n,
    input  cst_pkg::cmd_t    cmd,
    input  cst_pkg::pair_t   pair,
    input  logic             cfg_we,
    input  logic [15:0]      cfg_wdata,
    input  logic             result_stall,
    output cst_pkg::sts_t    sts,
    output logic             result_valid,
    output cst_pkg::result_t result
);
    import cst_pkg::*;

    // sums
    logic signed [SUM_W-1:0] dot_reg, dot_next;
    logic [SUM_W-1:0]        na_reg, na_next;
    logic [SUM_W-1:0]        nb_reg, nb_next;
    // product / square root
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [ROOT_W-1:0]       root_reg, root_next;
    logic [REM_W-1:0]        rem_reg, rem_next;
    // divide
    logic [SUM_W:0]          drem_reg, drem_next;
    logic [Q_W-1:0]          q_reg, q_next;
    logic                    neg_reg, neg_next;
    logic                    sat_reg, sat_next;
    // config and output
    logic signed [15:0]      thr_reg;
    logic                    result_valid_reg, result_valid_next;
    result_t                 result_reg, result_next;

    logic signed [31:0]      prod_ab, prod_aa, prod_bb;
    logic signed [SUM_W:0]   dot_wide;
    logic [SUM_W:0]          na_wide, nb_wide;
    logic [HALF_W-1:0]       a_part, b_part;
    logic [2*HALF_W-1:0]     pp;
    logic [PROD_W-1:0]       pp_shift;
    logic [REM_W+1:0]        rem_sh, trial, rem_diff;
    logic                    sq_ge;
    logic [SUM_W-1:0]        mag;
    logic [SUM_W:0]          drem_sh;
    logic                    d_ge;
    logic                    zero;
    logic signed [15:0]      sim;

    always_comb
    begin
        prod_ab  = pair.elem_a * pair.elem_b;
        prod_aa  = pair.elem_a * pair.elem_a;
        prod_bb  = pair.elem_b * pair.elem_b;
        dot_wide = (SUM_W+1)'(dot_reg) + (SUM_W+1)'(prod_ab);
        na_wide  = {1'b0, na_reg} + (SUM_W+1)'($unsigned(prod_aa));
        nb_wide  = {1'b0, nb_reg} + (SUM_W+1)'($unsigned(prod_bb));

        a_part = cmd.mul_sel[0] ? HALF_W'(na_reg[SUM_W-1:HALF_W]) : na_reg[HALF_W-1:0];
        b_part = cmd.mul_sel[1] ? HALF_W'(nb_reg[SUM_W-1:HALF_W]) : nb_reg[HALF_W-1:0];
        pp     = a_part * b_part;
        case (cmd.mul_sel)
            2'd0:    pp_shift = PROD_W'(pp);
            2'd3:    pp_shift = PROD_W'(pp) << (2 * HALF_W);
            default: pp_shift = PROD_W'(pp) << HALF_W;
        endcase

        rem_sh   = {rem_reg, prod_reg[PROD_W-1 -: 2]};
        trial    = {2'b00, root_reg, 2'b01};
        sq_ge    = (rem_sh >= trial);
        rem_diff = rem_sh - trial;

        mag     = dot_reg[SUM_W-1] ? SUM_W'(-dot_reg) : dot_reg;
        drem_sh = {drem_reg[SUM_W-1:0], 1'b0};
        d_ge    = (drem_sh >= {1'b0, root_reg});

        zero = (na_reg == '0) || (nb_reg == '0);
        if (zero)
            sim = '0;
        else if (neg_reg)
            sim = sat_reg ? SIM_MIN : -$signed({1'b0, q_reg});
        else
            sim = sat_reg ? SIM_MAX : $signed({1'b0, q_reg});
    end

    always_comb
    begin
        dot_next          = dot_reg;
        na_next           = na_reg;
        nb_next           = nb_reg;
        prod_next         = prod_reg;
        root_next         = root_reg;
        rem_next          = rem_reg;
        drem_next         = drem_reg;
        q_next            = q_reg;
        neg_next          = neg_reg;
        sat_next          = sat_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;

        if (result_valid_reg && !result_stall)
            result_valid_next = 1'b0;

        if (cmd.accum)
        begin
            // saturate when the top two bits disagree
            if (dot_wide[SUM_W] != dot_wide[SUM_W-1])
                dot_next = dot_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                           : {1'b0, {(SUM_W-1){1'b1}}};
            else
                dot_next = dot_wide[SUM_W-1:0];
            na_next = na_wide[SUM_W] ? '1 : na_wide[SUM_W-1:0];
            nb_next = nb_wide[SUM_W] ? '1 : nb_wide[SUM_W-1:0];
        end

        if (cmd.mul_step)
        begin
            prod_next = ((cmd.mul_sel == 2'd0) ? '0 : prod_reg) + pp_shift;
            root_next = '0;
            rem_next  = '0;
        end

        if (cmd.sqrt_step)
        begin
            rem_next  = sq_ge ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
            root_next = {root_reg[ROOT_W-2:0], sq_ge};
            prod_next = {prod_reg[PROD_W-3:0], 2'b00};
        end

        if (cmd.div_prep)
        begin
            neg_next  = dot_reg[SUM_W-1];
            sat_next  = (mag >= root_reg);
            drem_next = {1'b0, mag};
            q_next    = '0;
        end

        if (cmd.div_step)
        begin
            drem_next = d_ge ? (drem_sh - {1'b0, root_reg}) : drem_sh;
            q_next    = {q_reg[Q_W-2:0], d_ge};
        end

        if (cmd.load)
        begin
            result_next.similarity      = sim;
            result_next.above_threshold = !zero && (sim > thr_reg);
            result_next.zero_norm       = zero;
            result_valid_next           = 1'b1;
            dot_next                    = '0;
            na_next                     = '0;
            nb_next                     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg          <= '0;
            na_reg           <= '0;
            nb_reg           <= '0;
            thr_reg          <= THRESHOLD_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            dot_reg          <= dot_next;
            na_reg           <= na_next;
            nb_reg           <= nb_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we)
                thr_reg <= $signed(cfg_wdata);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        root_reg   <= root_next;
        rem_reg    <= rem_next;
        drem_reg   <= drem_next;
        q_reg      <= q_next;
        neg_reg    <= neg_next;
        sat_reg    <= sat_next;
        result_reg <= result_next;
    end

    assign sts.out_free  = !result_valid_reg || !result_stall;
    assign result_valid  = result_valid_reg;
    assign result        = result_reg;

endmodule

`default_nettype wire

// File: hw/rtl/cosine_similarity_threshold.sv
// Top level of the cosine similarity threshold block.
//
//  channel    signals                          transfer when
//  pair       pair_valid, pair_stall, pair     pair_valid && !pair_stall
//  result     result_valid, result_stall, res. result_valid && !result_stall
//  config     cfg_we, cfg_wdata                cfg_we (threshold, Q1.15)
//
// Element pairs transfer one per cycle while the sums accumulate.
// After the pair marked last, pair_stall stays high for the finishing
// sequence: split 43x43 product, digit-by-digit square root, a setup step
// and restoring divide, then the result register loads; the load waits
// while an earlier result is held by result_stall.
// Reset (rst_n low, asynchronous) clears the sums and sets threshold to 0.35.
`default_nettype none

module cosine_similarity_threshold (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pair_valid,
    output logic             pair_stall,
    input  cst_pkg::pair_t   pair,
    output logic             result_valid,
    input  logic             result_stall,
    output cst_pkg::result_t result,
    input  logic             cfg_we,
    input  logic [15:0]      cfg_wdata
);
    import cst_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic busy;
    logic pair_fire;

    // pairs are taken only in the accumulate state
    assign pair_stall = busy;
    assign pair_fire  = pair_valid && !busy;

    cst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pair_fire (pair_fire),
        .pair_last (pair.last),
        .sts       (sts),
        .cmd       (cmd),
        .busy      (busy)
    );

    // result register lets sums restart while a result waits downstream
    cst_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .pair         (pair),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .result_stall (result_stall),
        .sts          (sts),
        .result_valid (result_valid),
        .result       (result)
    );

    // a zero-norm result carries similarity 0 and no match
    a_zero_norm: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.zero_norm
        |-> result.similarity == 16'sd0 && !result.above_threshold)
        else $error("zero-norm result with nonzero similarity or match");

    // the final pair starts the finishing sequence
    a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        pair_fire && pair.last |=> pair_stall)
        else $error("input not stalled after final pair");

    // the finishing sequence opens with the first product step (mul_sel 0)
    a_mul_order: assert property (@(posedge clk) disable iff (!rst_n)
        pair_fire && pair.last |=> cmd.mul_step && cmd.mul_sel == 2'd0)
        else $error("product sequence did not start after final pair");

endmodule

`default_nettype wire
